[rtl/core/cia_pkg.sv]
package cia_pkg;

    localparam int VAL_W          = 64;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int Q_DEPTH        = 2;
    localparam int MUL_CHUNK      = 16;

    localparam logic [1:0] ERR_DIV_ZERO = 2'd0;
    localparam logic [1:0] ERR_BAD_OP   = 2'd1;

    typedef enum logic [3:0] {
        M_ADD = 4'd0,
        M_SUB = 4'd1,
        M_DIV = 4'd2,
        M_MUL = 4'd3,
        M_MOD = 4'd4,
        M_POW = 4'd5,
        M_MIN = 4'd6,
        M_MAX = 4'd7
    } t_mode;

    typedef enum logic [3:0] {
        K_ERR,
        K_ADD,
        K_SUB,
        K_MIN,
        K_MAX,
        K_DIV,
        K_MOD,
        K_MUL,
        K_POW
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] code;
    } t_tag;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_MUL,
        B_FIN
    } t_bstate;

endpackage

[rtl/core/checked_integer_alu_top.sv]
// Integer ALU on two tagged operands (number or error code). An error operand
// passes straight through, the left one first; otherwise add, sub, div, mul,
// mod, pow, min or max is computed on DATA_WIDTH-bit two's-complement values
// and the result is sign-extended to 64 bits. A front decoder classifies each
// transfer into a two-entry queue; a back unit executes one item at a time and
// holds its result in an output register, so a new item can be taken while a
// result waits. Add, sub, min, max and error results are produced directly;
// div and mod load, run a restoring divider with one quotient bit per cycle,
// then finish; mul passes through the NCH = ceil(DATA_WIDTH/16) 16-bit
// multiplier chunks; pow with a positive exponent repeats that pass for each
// significant exponent bit (square and multiply share the chunk pass), and
// gives 1 otherwise. A zero divisor or an unknown mode gives an error result.
module checked_integer_alu_top #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_mode,
    input  logic signed [63:0] i_left_value,
    input  logic               i_left_is_error,
    input  logic [1:0]         i_left_error_code,
    input  logic signed [63:0] i_right_value,
    input  logic               i_right_is_error,
    input  logic [1:0]         i_right_error_code,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_result_value,
    output logic               o_result_is_error,
    output logic [1:0]         o_error_code
);
    import cia_pkg::*;

    localparam int TAG_W = $bits(t_tag);
    localparam int PW    = TAG_W + 2 * DATA_WIDTH;

    logic                  q_full, q_empty, push, pop;
    t_tag                  f_tag, b_tag;
    logic [DATA_WIDTH-1:0] f_a, f_b, b_a, b_b;
    logic [PW-1:0]         q_out;

    cia_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_left_value       (i_left_value),
        .i_left_is_error    (i_left_is_error),
        .i_left_error_code  (i_left_error_code),
        .i_right_value      (i_right_value),
        .i_right_is_error   (i_right_is_error),
        .i_right_error_code (i_right_error_code),
        .i_q_full           (q_full),
        .o_push             (push),
        .o_tag              (f_tag),
        .o_a                (f_a),
        .o_b                (f_b)
    );

    cia_queue #(
        .WIDTH (PW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_tag, f_a, f_b}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign b_tag = t_tag'(q_out[PW-1 -: TAG_W]);
    assign b_a   = q_out[2*DATA_WIDTH-1 -: DATA_WIDTH];
    assign b_b   = q_out[DATA_WIDTH-1:0];

    cia_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_tag             (b_tag),
        .i_a               (b_a),
        .i_b               (b_b),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_value    (o_result_value),
        .o_result_is_error (o_result_is_error),
        .o_error_code      (o_error_code)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("back unit popped an empty queue");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_is_error |-> o_result_value == '0)
        else $error("error result carries a nonzero value");

    a_ok_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_is_error |-> o_error_code == ERR_DIV_ZERO)
        else $error("numeric result carries an error code");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full && !pop |=> q_full)
        else $error("queue lost an entry while full");

endmodule

[rtl/core/cia_front.sv]
module cia_front #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [3:0]              i_mode,
    input  logic signed [63:0]      i_left_value,
    input  logic                    i_left_is_error,
    input  logic [1:0]              i_left_error_code,
    input  logic signed [63:0]      i_right_value,
    input  logic                    i_right_is_error,
    input  logic [1:0]              i_right_error_code,
    input  logic                    i_q_full,
    output logic                    o_push,
    output cia_pkg::t_tag           o_tag,
    output logic [DATA_WIDTH-1:0]   o_a,
    output logic [DATA_WIDTH-1:0]   o_b
);
    import cia_pkg::*;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_a        = i_left_value[DATA_WIDTH-1:0];
    assign o_b        = i_right_value[DATA_WIDTH-1:0];

    // operand errors win over everything, left first
    always_comb begin
        o_tag.kind = K_ERR;
        o_tag.code = ERR_DIV_ZERO;
        if (i_left_is_error) begin
            o_tag.code = i_left_error_code;
        end else if (i_right_is_error) begin
            o_tag.code = i_right_error_code;
        end else begin
            case (t_mode'(i_mode))
                M_ADD: o_tag.kind = K_ADD;
                M_SUB: o_tag.kind = K_SUB;
                M_MUL: o_tag.kind = K_MUL;
                M_POW: o_tag.kind = K_POW;
                M_MIN: o_tag.kind = K_MIN;
                M_MAX: o_tag.kind = K_MAX;
                M_DIV: begin
                    if (o_b != '0) o_tag.kind = K_DIV;
                end
                M_MOD: begin
                    if (o_b != '0) o_tag.kind = K_MOD;
                end
                default: o_tag.code = ERR_BAD_OP;
            endcase
        end
    end

endmodule

[rtl/core/cia_queue.sv]
module cia_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    import cia_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/cia_back.sv]
module cia_back #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  cia_pkg::t_tag         i_tag,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [63:0]    o_result_value,
    output logic                  o_result_is_error,
    output logic [1:0]            o_error_code
);
    import cia_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int CH    = (W < MUL_CHUNK) ? W : MUL_CHUNK;
    localparam int NCH   = (W + CH - 1) / CH;
    localparam int CNT_W = $clog2(W + 1);

    t_bstate r_state, n_state;
    logic    r_o_valid, n_o_valid;

    logic signed [VAL_W-1:0] r_o_value, n_o_value;
    logic                    r_o_err, n_o_err;
    logic [1:0]              r_o_code, n_o_code;

    logic [W-1:0]     r_res, n_res;
    logic [W-1:0]     r_x1, n_x1, r_x2, n_x2, r_y, n_y, r_p1, n_p1, r_p2, n_p2;
    logic [W-1:0]     r_acc, n_acc, r_exp, n_exp;
    logic [W-1:0]     r_rem, n_rem, r_quo, n_quo, r_div, n_div;
    logic             r_neg, n_neg, r_mod, n_mod, r_pow, n_pow;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [W+CH-1:0] prod1, prod2;
    logic [W-1:0]    s1, s2;
    logic [W:0]      div_t, div_d;
    logic            div_ge;
    logic [W-1:0]    div_rem, div_quo, div_sel;
    logic            out_free;
    logic [W-1:0]    quick;

    // one chunk of the multiplier per cycle, two products share it
    assign prod1 = r_x1 * r_y[CH-1:0];
    assign prod2 = r_x2 * r_y[CH-1:0];
    assign s1    = r_p1 + prod1[W-1:0];
    assign s2    = r_p2 + prod2[W-1:0];

    // restoring divider, one quotient bit per cycle
    assign div_t   = {r_rem, r_quo[W-1]};
    assign div_d   = {1'b0, r_div};
    assign div_ge  = (div_t >= div_d);
    assign div_rem = div_ge ? W'(div_t - div_d) : div_t[W-1:0];
    assign div_quo = {r_quo[W-2:0], div_ge};
    assign div_sel = r_mod ? div_rem : div_quo;

    assign out_free = !r_o_valid || !i_out_stall;

    always_comb begin
        case (i_tag.kind)
            K_ADD:   quick = i_a + i_b;
            K_SUB:   quick = i_a - i_b;
            K_MIN:   quick = ($signed(i_a) < $signed(i_b)) ? i_a : i_b;
            K_MAX:   quick = ($signed(i_b) < $signed(i_a)) ? i_a : i_b;
            default: quick = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_o_valid = r_o_valid;
        n_o_value = r_o_value;
        n_o_err   = r_o_err;
        n_o_code  = r_o_code;
        n_res     = r_res;
        n_x1      = r_x1;
        n_x2      = r_x2;
        n_y       = r_y;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_acc     = r_acc;
        n_exp     = r_exp;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_div     = r_div;
        n_neg     = r_neg;
        n_mod     = r_mod;
        n_pow     = r_pow;
        n_cnt     = r_cnt;
        o_pop     = 1'b0;

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    case (i_tag.kind)
                        K_DIV, K_MOD: begin
                            o_pop   = 1'b1;
                            n_quo   = i_a[W-1] ? W'(-i_a) : i_a;
                            n_div   = i_b[W-1] ? W'(-i_b) : i_b;
                            n_rem   = '0;
                            n_mod   = (i_tag.kind == K_MOD);
                            n_neg   = (i_tag.kind == K_MOD) ? i_a[W-1]
                                                            : (i_a[W-1] ^ i_b[W-1]);
                            n_cnt   = CNT_W'(W);
                            n_state = B_DIV;
                        end
                        K_MUL: begin
                            o_pop   = 1'b1;
                            n_x1    = i_a;
                            n_x2    = i_a;
                            n_y     = i_b;
                            n_p1    = '0;
                            n_p2    = '0;
                            n_pow   = 1'b0;
                            n_cnt   = CNT_W'(NCH);
                            n_state = B_MUL;
                        end
                        K_POW: begin
                            o_pop = 1'b1;
                            if (i_b[W-1] || i_b == '0) begin
                                n_res   = W'(1);
                                n_state = B_FIN;
                            end else begin
                                n_acc   = W'(1);
                                n_exp   = i_b;
                                n_x1    = W'(1);
                                n_x2    = i_a;
                                n_y     = i_a;
                                n_p1    = '0;
                                n_p2    = '0;
                                n_pow   = 1'b1;
                                n_cnt   = CNT_W'(NCH);
                                n_state = B_MUL;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                o_pop     = 1'b1;
                                n_o_valid = 1'b1;
                                if (i_tag.kind == K_ERR) begin
                                    n_o_value = '0;
                                    n_o_err   = 1'b1;
                                    n_o_code  = i_tag.code;
                                end else begin
                                    n_o_value = VAL_W'($signed(quick));
                                    n_o_err   = 1'b0;
                                    n_o_code  = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            B_DIV: begin
                n_rem = div_rem;
                n_quo = div_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_res   = r_neg ? W'(-div_sel) : div_sel;
                    n_state = B_FIN;
                end
            end
            B_MUL: begin
                n_p1  = s1;
                n_p2  = s2;
                n_x1  = r_x1 << CH;
                n_x2  = r_x2 << CH;
                n_y   = r_y >> CH;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    if (!r_pow) begin
                        n_res   = s1;
                        n_state = B_FIN;
                    end else begin
                        // s1 = acc * base, s2 = base * base
                        if (r_exp[0]) n_acc = s1;
                        n_exp  = r_exp >> 1;
                        if ((r_exp >> 1) == '0) begin
                            n_res   = s1;
                            n_state = B_FIN;
                        end else begin
                            n_x1  = r_exp[0] ? s1 : r_acc;
                            n_x2  = s2;
                            n_y   = s2;
                            n_p1  = '0;
                            n_p2  = '0;
                            n_cnt = CNT_W'(NCH);
                        end
                    end
                end
            end
            B_FIN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_value = VAL_W'($signed(r_res));
                    n_o_err   = 1'b0;
                    n_o_code  = '0;
                    n_state   = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_value <= n_o_value;
        r_o_err   <= n_o_err;
        r_o_code  <= n_o_code;
        r_res     <= n_res;
        r_x1      <= n_x1;
        r_x2      <= n_x2;
        r_y       <= n_y;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_acc     <= n_acc;
        r_exp     <= n_exp;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div     <= n_div;
        r_neg     <= n_neg;
        r_mod     <= n_mod;
        r_pow     <= n_pow;
        r_cnt     <= n_cnt;
    end

    assign o_out_valid       = r_o_valid;
    assign o_result_value    = r_o_value;
    assign o_result_is_error = r_o_err;
    assign o_error_code      = r_o_code;

endmodule
